// File: src/atc_pkg.sv
// Shared constants, command/status types and widths for the accelerometer
// tilt calibration and correction block. No dependencies.
package atc_pkg;

    localparam int ACCEL_BITS  = 16;
    localparam int FRAC_BITS   = 15;
    localparam int CNT_W       = 11;
    localparam int MAX_SAMPLES = 1024;
    localparam int CALIB_RESET = 100;

    localparam int SUM_W   = ACCEL_BITS + 11;          // 1024 samples of 16 bits
    localparam int MAG_W   = SUM_W - 1;
    localparam int SQ_W    = 2 * MAG_W - 1;
    localparam int RAD_W   = SQ_W + 1;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int QUO_W   = FRAC_BITS + 1;
    localparam int DIV_W   = MAG_W + FRAC_BITS + 1;
    localparam int TRIG_W  = FRAC_BITS + 2;
    localparam int OUT_W   = ACCEL_BITS + 1;
    localparam int MUL_W   = SUM_W;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 2 * TRIG_W + 3;
    localparam int IN_DATA_W  = 3 * ACCEL_BITS;
    localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;
    localparam int OUT_PAD    = OUT_DATA_W - 3 * OUT_W;

    // Multiplier operand pair; the same code names where the product goes.
    typedef enum logic [3:0] {
        MS_NONE, MS_XX, MS_YY, MS_ZZ,
        MS_SXSY, MS_SXKY, MS_KXSY, MS_KXKY,
        MS_KX_X, MS_R12_Y, MS_R13_Z, MS_KY_Y,
        MS_SY_Z, MS_SX_X, MS_R32_Y, MS_R33_Z
    } mul_sel_t;

    typedef enum logic [1:0] {
        OK_CAL, OK_DONE, OK_PASS, OK_CORR
    } out_kind_t;

    typedef struct packed {
        logic      accept;
        mul_sel_t  mul_sel;
        logic      root_start;
        logic [1:0] root_sel;
        logic      div_start;
        logic [1:0] div_sel;
        logic      tilt_default;
        logic      latch_cx;
        logic      latch_cy;
        logic      out_load;
        out_kind_t out_kind;
    } cmd_t;

    typedef struct packed {
        logic func;
        logic last;
        logic calibrated;
        logic root_done;
        logic div_done;
        logic norm_zero;
    } status_t;

endpackage

// File: src/atc_isqrt.sv
// Floor square root, two radicand bits per cycle.
// Depends on atc_pkg for widths.
module atc_isqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [atc_pkg::RAD_W-1:0]  radicand,
    output logic [atc_pkg::ROOT_W-1:0] root,
    output logic                       done
);
    localparam int RW  = atc_pkg::ROOT_W;
    localparam int CW  = $clog2(RW);

    logic [atc_pkg::RAD_W-1:0] rad_reg;
    logic [RW+1:0]             rem_reg;
    logic [RW-1:0]             root_reg;
    logic [CW-1:0]             cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [RW+3:0]             rem_sh;
    logic [RW+3:0]             trial;
    logic                      fits;

    always_comb begin
        rem_sh = {rem_reg, rad_reg[atc_pkg::RAD_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CW'(RW - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rad_reg  <= {rad_reg[atc_pkg::RAD_W-3:0], 2'b00};
                rem_reg  <= fits ? (RW+2)'(rem_sh - trial) : rem_sh[RW+1:0];
                root_reg <= {root_reg[RW-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;
endmodule

// File: src/atc_div.sv
// Rounded Q1.15 ratio num/den by restoring division, one quotient bit a cycle.
// Depends on atc_pkg; requires num <= den and den != 0.
module atc_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [atc_pkg::MAG_W-1:0]  num,
    input  logic [atc_pkg::ROOT_W-1:0] den,
    output logic [atc_pkg::QUO_W-1:0]  quo,
    output logic                       done
);
    localparam int QW = atc_pkg::QUO_W;
    localparam int DW = atc_pkg::DIV_W;
    localparam int RW = atc_pkg::ROOT_W;
    localparam int CW = $clog2(QW);

    logic [DW-1:0] dividend;
    logic [RW-1:0] den_reg;
    logic [RW-1:0] rem_reg;
    logic [QW-1:0] low_reg;
    logic [QW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [RW:0]   rem_sh;
    logic          fits;

    always_comb begin
        // Adding half the divisor turns the floor into round-half-up.
        dividend = {num, {atc_pkg::FRAC_BITS{1'b0}}} + DW'(den >> 1);
        rem_sh   = {rem_reg, low_reg[QW-1]};
        fits     = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                den_reg  <= den;
                rem_reg  <= dividend[DW-1:QW];
                low_reg  <= dividend[QW-1:0];
                quo_reg  <= '0;
                cnt_reg  <= CW'(QW - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= fits ? RW'(rem_sh - {1'b0, den_reg}) : rem_sh[RW-1:0];
                low_reg  <= {low_reg[QW-2:0], 1'b0};
                quo_reg  <= {quo_reg[QW-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;
endmodule

// File: src/atc_dpath.sv
// Datapath: sums, count, tilt terms, shared multiplier, root and divide units,
// and the result register. Depends on atc_pkg, atc_isqrt and atc_div.
module atc_dpath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [atc_pkg::CNT_W-1:0]         cfg_data,
    output logic                              cfg_ready,
    input  logic [atc_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    output logic [atc_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [1:0]                        m_tuser,
    input  atc_pkg::cmd_t                     cmd,
    output atc_pkg::status_t                  status
);
    localparam int AB = atc_pkg::ACCEL_BITS;
    localparam int FB = atc_pkg::FRAC_BITS;
    localparam int SW = atc_pkg::SUM_W;
    localparam int MW = atc_pkg::MAG_W;
    localparam int TW = atc_pkg::TRIG_W;
    localparam int OW = atc_pkg::OUT_W;
    localparam int AW = atc_pkg::ACC_W;
    localparam int PW = atc_pkg::PROD_W;
    localparam int CW = atc_pkg::CNT_W;
    localparam logic signed [TW-1:0] ONE_Q   = TW'(1 << FB);
    localparam logic signed [PW-1:0] HALF_P  = PW'(1 << (FB - 1));
    localparam logic signed [AW-1:0] HALF_A  = AW'(1 << (FB - 1));
    localparam logic signed [AW-1:0] SAT_HI  = AW'((1 << AB) - 1);
    localparam logic signed [AW-1:0] SAT_LO  = -AW'(1 << AB);

    function automatic logic [MW-1:0] mag_f(input logic signed [SW-1:0] v);
        logic [SW-1:0] t;
        t = v[SW-1] ? -v : v;
        return t[MW-1:0];
    endfunction

    logic [CW-1:0]                 calib_samples_reg;
    logic [CW-1:0]                 count_reg;
    logic signed [SW-1:0]          sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [AB-1:0]          x_reg, y_reg, z_reg;
    logic [atc_pkg::SQ_W-1:0]      sq_x_reg, sq_y_reg, sq_z_reg;
    logic [atc_pkg::ROOT_W-1:0]    norm_reg, cyn_reg, cxn_reg;
    logic signed [TW-1:0]          sin_x_reg, cos_x_reg, sin_y_reg, cos_y_reg;
    logic signed [TW-1:0]          r12_reg, r13_reg, r32_reg, r33_reg;
    logic signed [PW-1:0]          prod_reg;
    atc_pkg::mul_sel_t             pend_reg;
    logic signed [AW-1:0]          acc_reg;
    logic signed [OW-1:0]          cx_reg, cy_reg;
    logic signed [OW-1:0]          ox_reg, oy_reg, oz_reg;
    logic                          is_cal_reg, done_out_reg, calibrated_reg;
    logic [1:0]                    root_sel_reg, div_sel_reg;

    logic signed [AB-1:0]          in_x, in_y, in_z;
    logic [MW-1:0]                 ax, ay, az;
    logic signed [atc_pkg::MUL_W-1:0] mul_a, mul_b;
    logic signed [PW-1:0]          prod_rnd_full;
    logic signed [TW-1:0]          prod_rnd;
    logic signed [AW-1:0]          prod_acc;
    logic signed [AW-1:0]          acc_rnd;
    logic signed [OW-1:0]          acc_sat;
    logic [CW-1:0]                 target;
    logic [atc_pkg::RAD_W-1:0]     radicand;
    logic [atc_pkg::ROOT_W-1:0]    root;
    logic                          root_done;
    logic [MW-1:0]                 div_num;
    logic [atc_pkg::QUO_W-1:0]     quo;
    logic                          div_done;
    logic signed [TW-1:0]          quo_s;

    assign in_x = s_tdata[AB-1:0];
    assign in_y = s_tdata[2*AB-1:AB];
    assign in_z = s_tdata[3*AB-1:2*AB];
    assign ax   = mag_f(sum_x_reg);
    assign ay   = mag_f(sum_y_reg);
    assign az   = mag_f(sum_z_reg);
    assign cfg_ready = 1'b1;

    always_comb begin
        // A count of zero acts as one and anything above the maximum is clipped.
        if (calib_samples_reg == '0) begin
            target = CW'(1);
        end else if (calib_samples_reg > CW'(atc_pkg::MAX_SAMPLES)) begin
            target = CW'(atc_pkg::MAX_SAMPLES);
        end else begin
            target = calib_samples_reg;
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            atc_pkg::MS_XX:    begin mul_a = {1'b0, ax}; mul_b = {1'b0, ax}; end
            atc_pkg::MS_YY:    begin mul_a = {1'b0, ay}; mul_b = {1'b0, ay}; end
            atc_pkg::MS_ZZ:    begin mul_a = {1'b0, az}; mul_b = {1'b0, az}; end
            atc_pkg::MS_SXSY:  begin mul_a = SW'(sin_x_reg); mul_b = SW'(sin_y_reg); end
            atc_pkg::MS_SXKY:  begin mul_a = SW'(sin_x_reg); mul_b = SW'(cos_y_reg); end
            atc_pkg::MS_KXSY:  begin mul_a = SW'(cos_x_reg); mul_b = SW'(sin_y_reg); end
            atc_pkg::MS_KXKY:  begin mul_a = SW'(cos_x_reg); mul_b = SW'(cos_y_reg); end
            atc_pkg::MS_KX_X:  begin mul_a = SW'(cos_x_reg); mul_b = SW'(x_reg); end
            atc_pkg::MS_R12_Y: begin mul_a = SW'(r12_reg);   mul_b = SW'(y_reg); end
            atc_pkg::MS_R13_Z: begin mul_a = SW'(r13_reg);   mul_b = SW'(z_reg); end
            atc_pkg::MS_KY_Y:  begin mul_a = SW'(cos_y_reg); mul_b = SW'(y_reg); end
            atc_pkg::MS_SY_Z:  begin mul_a = SW'(sin_y_reg); mul_b = SW'(z_reg); end
            atc_pkg::MS_SX_X:  begin mul_a = SW'(sin_x_reg); mul_b = SW'(x_reg); end
            atc_pkg::MS_R32_Y: begin mul_a = SW'(r32_reg);   mul_b = SW'(y_reg); end
            atc_pkg::MS_R33_Z: begin mul_a = SW'(r33_reg);   mul_b = SW'(z_reg); end
            default:           begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        prod_rnd_full = (prod_reg + HALF_P) >>> FB;
        prod_rnd      = TW'(prod_rnd_full);
        prod_acc      = AW'(prod_reg);
        acc_rnd       = (acc_reg + HALF_A) >>> FB;
        if (acc_rnd > SAT_HI) begin
            acc_sat = OW'(SAT_HI);
        end else if (acc_rnd < SAT_LO) begin
            acc_sat = OW'(SAT_LO);
        end else begin
            acc_sat = OW'(acc_rnd);
        end
    end

    always_comb begin
        case (cmd.root_sel)
            2'd0:    radicand = sq_x_reg + sq_y_reg + sq_z_reg;
            2'd1:    radicand = atc_pkg::RAD_W'(sq_y_reg) + sq_z_reg;
            default: radicand = atc_pkg::RAD_W'(sq_x_reg) + sq_z_reg;
        endcase
        case (cmd.div_sel)
            2'd0:    div_num = ax;
            2'd1:    div_num = ay;
            2'd2:    div_num = cyn_reg;
            default: div_num = cxn_reg;
        endcase
        quo_s = TW'(quo);
    end

    atc_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.root_start),
        .radicand (radicand),
        .root     (root),
        .done     (root_done)
    );

    atc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (norm_reg),
        .quo     (quo),
        .done    (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calib_samples_reg <= CW'(atc_pkg::CALIB_RESET);
            count_reg         <= '0;
            sum_x_reg         <= '0;
            sum_y_reg         <= '0;
            sum_z_reg         <= '0;
            calibrated_reg    <= 1'b0;
            pend_reg          <= atc_pkg::MS_NONE;
            sin_x_reg         <= '0;
            sin_y_reg         <= '0;
            cos_x_reg         <= ONE_Q;
            cos_y_reg         <= ONE_Q;
        end else begin
            if (cfg_valid) begin
                calib_samples_reg <= cfg_data;
            end
            if (cmd.accept) begin
                x_reg <= in_x;
                y_reg <= in_y;
                z_reg <= in_z;
                if (!s_tuser) begin
                    sum_x_reg <= sum_x_reg + SW'(in_x);
                    sum_y_reg <= sum_y_reg + SW'(in_y);
                    sum_z_reg <= sum_z_reg + SW'(in_z);
                    count_reg <= count_reg + 1'b1;
                end
            end

            prod_reg <= mul_a * mul_b;
            pend_reg <= cmd.mul_sel;
            case (pend_reg)
                atc_pkg::MS_XX:    sq_x_reg <= prod_reg[atc_pkg::SQ_W-1:0];
                atc_pkg::MS_YY:    sq_y_reg <= prod_reg[atc_pkg::SQ_W-1:0];
                atc_pkg::MS_ZZ:    sq_z_reg <= prod_reg[atc_pkg::SQ_W-1:0];
                atc_pkg::MS_SXSY:  r12_reg  <= prod_rnd;
                atc_pkg::MS_SXKY:  r13_reg  <= prod_rnd;
                atc_pkg::MS_KXSY:  r32_reg  <= prod_rnd;
                atc_pkg::MS_KXKY:  r33_reg  <= prod_rnd;
                atc_pkg::MS_KX_X,
                atc_pkg::MS_KY_Y:  acc_reg  <= prod_acc;
                atc_pkg::MS_SX_X:  acc_reg  <= -prod_acc;
                atc_pkg::MS_SY_Z:  acc_reg  <= acc_reg - prod_acc;
                atc_pkg::MS_R12_Y,
                atc_pkg::MS_R13_Z,
                atc_pkg::MS_R32_Y,
                atc_pkg::MS_R33_Z: acc_reg  <= acc_reg + prod_acc;
                default: ;
            endcase

            if (cmd.latch_cx) cx_reg <= acc_sat;
            if (cmd.latch_cy) cy_reg <= acc_sat;

            if (cmd.root_start) root_sel_reg <= cmd.root_sel;
            if (root_done) begin
                case (root_sel_reg)
                    2'd0:    norm_reg <= root;
                    2'd1:    cyn_reg  <= root;
                    default: cxn_reg  <= root;
                endcase
            end

            if (cmd.div_start) div_sel_reg <= cmd.div_sel;
            if (div_done) begin
                case (div_sel_reg)
                    2'd0:    sin_x_reg <= sum_x_reg[SW-1] ? -quo_s : quo_s;
                    2'd1:    sin_y_reg <= sum_y_reg[SW-1] ? -quo_s : quo_s;
                    2'd2:    cos_x_reg <= quo_s;
                    default: cos_y_reg <= quo_s;
                endcase
            end

            if (cmd.tilt_default) begin
                sin_x_reg <= '0;
                sin_y_reg <= '0;
                cos_x_reg <= ONE_Q;
                cos_y_reg <= ONE_Q;
            end

            if (cmd.out_load) begin
                case (cmd.out_kind)
                    atc_pkg::OK_DONE: begin
                        ox_reg         <= '0;
                        oy_reg         <= '0;
                        oz_reg         <= '0;
                        is_cal_reg     <= 1'b1;
                        done_out_reg   <= 1'b1;
                        calibrated_reg <= 1'b1;
                        sum_x_reg      <= '0;
                        sum_y_reg      <= '0;
                        sum_z_reg      <= '0;
                        count_reg      <= '0;
                    end
                    atc_pkg::OK_PASS: begin
                        ox_reg       <= OW'(in_x);
                        oy_reg       <= OW'(in_y);
                        oz_reg       <= OW'(in_z);
                        is_cal_reg   <= calibrated_reg;
                        done_out_reg <= 1'b0;
                    end
                    atc_pkg::OK_CORR: begin
                        ox_reg       <= cx_reg;
                        oy_reg       <= cy_reg;
                        oz_reg       <= acc_sat;
                        is_cal_reg   <= calibrated_reg;
                        done_out_reg <= 1'b0;
                    end
                    default: begin
                        ox_reg       <= '0;
                        oy_reg       <= '0;
                        oz_reg       <= '0;
                        is_cal_reg   <= calibrated_reg;
                        done_out_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign m_tdata = {{atc_pkg::OUT_PAD{1'b0}}, oz_reg, oy_reg, ox_reg};
    assign m_tuser = {done_out_reg, is_cal_reg};

    always_comb begin
        status.func       = s_tuser;
        status.last       = ({1'b0, count_reg} + 1'b1) >= {1'b0, target};
        status.calibrated = calibrated_reg;
        status.root_done  = root_done;
        status.div_done   = div_done;
        status.norm_zero  = (norm_reg == '0);
    end
endmodule

// File: src/atc_ctrl.sv
// Controller: sequences the calibration finish and the correction passes and
// owns the stream handshakes. Depends on atc_pkg.
module atc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  atc_pkg::status_t status,
    output atc_pkg::cmd_t    cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_ROOT, S_ROOT_WAIT, S_CHECK,
        S_DIV, S_DIV_WAIT, S_PROD, S_FIN, S_COR
    } state_t;

    state_t     state_reg;
    logic [3:0] step_reg;
    logic [1:0] idx_reg;
    logic       m_tvalid_reg;

    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd          = '0;
        cmd.mul_sel  = atc_pkg::MS_NONE;
        cmd.out_kind = atc_pkg::OK_CAL;
        cmd.root_sel = idx_reg;
        cmd.div_sel  = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.accept = 1'b1;
                    if (!status.func && !status.last) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = atc_pkg::OK_CAL;
                    end else if (status.func && !status.calibrated) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = atc_pkg::OK_PASS;
                    end
                end
            end
            S_SQ: begin
                case (step_reg)
                    4'd0:    cmd.mul_sel = atc_pkg::MS_XX;
                    4'd1:    cmd.mul_sel = atc_pkg::MS_YY;
                    4'd2:    cmd.mul_sel = atc_pkg::MS_ZZ;
                    default: cmd.mul_sel = atc_pkg::MS_NONE;
                endcase
            end
            S_ROOT:  cmd.root_start = 1'b1;
            S_DIV:   cmd.div_start  = 1'b1;
            S_CHECK: cmd.tilt_default = status.norm_zero;
            S_PROD: begin
                case (step_reg)
                    4'd0:    cmd.mul_sel = atc_pkg::MS_SXSY;
                    4'd1:    cmd.mul_sel = atc_pkg::MS_SXKY;
                    4'd2:    cmd.mul_sel = atc_pkg::MS_KXSY;
                    4'd3:    cmd.mul_sel = atc_pkg::MS_KXKY;
                    default: cmd.mul_sel = atc_pkg::MS_NONE;
                endcase
            end
            S_FIN: begin
                cmd.out_load = 1'b1;
                cmd.out_kind = atc_pkg::OK_DONE;
            end
            S_COR: begin
                // Each product is registered in prod_reg before it lands in the accumulator.
                case (step_reg)
                    4'd0: cmd.mul_sel = atc_pkg::MS_KX_X;
                    4'd1: cmd.mul_sel = atc_pkg::MS_R12_Y;
                    4'd2: cmd.mul_sel = atc_pkg::MS_R13_Z;
                    4'd3: cmd.mul_sel = atc_pkg::MS_KY_Y;
                    4'd4: begin
                        cmd.mul_sel  = atc_pkg::MS_SY_Z;
                        cmd.latch_cx = 1'b1;
                    end
                    4'd5: cmd.mul_sel = atc_pkg::MS_SX_X;
                    4'd6: begin
                        cmd.mul_sel  = atc_pkg::MS_R32_Y;
                        cmd.latch_cy = 1'b1;
                    end
                    4'd7: cmd.mul_sel = atc_pkg::MS_R33_Z;
                    4'd9: begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = atc_pkg::OK_CORR;
                    end
                    default: cmd.mul_sel = atc_pkg::MS_NONE;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            step_reg <= step_reg + 1'b1;
            unique case (state_reg)
                S_IDLE: begin
                    step_reg <= '0;
                    idx_reg  <= '0;
                    if (cmd.accept) begin
                        if (!status.func && status.last) begin
                            state_reg <= S_SQ;
                        end else if (status.func && status.calibrated) begin
                            state_reg <= S_COR;
                        end
                    end
                end
                S_SQ: begin
                    if (step_reg == 4'd3) state_reg <= S_ROOT;
                end
                S_ROOT: state_reg <= S_ROOT_WAIT;
                S_ROOT_WAIT: begin
                    if (status.root_done) begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= (idx_reg == 2'd2) ? S_CHECK : S_ROOT;
                    end
                end
                S_CHECK: begin
                    idx_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= status.norm_zero ? S_PROD : S_DIV;
                end
                S_DIV: state_reg <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    step_reg <= '0;
                    if (status.div_done) begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= (idx_reg == 2'd3) ? S_PROD : S_DIV;
                    end
                end
                S_PROD: begin
                    if (step_reg == 4'd5) state_reg <= S_FIN;
                end
                S_FIN: state_reg <= S_IDLE;
                S_COR: begin
                    if (step_reg == 4'd9) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register loaded while a result is still pending");

    a_root_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        status.root_done |-> (state_reg == S_ROOT_WAIT))
        else $error("square root finished outside its wait state");

    a_div_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_done_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && cmd.out_kind == atc_pkg::OK_DONE) |=> status.calibrated)
        else $error("calibration finished without setting the calibrated flag");
endmodule

// File: src/accel_tilt_calibrate_correct.sv
// Accelerometer tilt calibration and correction, top level.
// Depends on atc_pkg, atc_ctrl and atc_dpath.
//
// Requests on the s_ channel carry one three-axis sample; tuser selects a
// calibration sample (0) or a sample to correct (1). Every request gives one
// result on the m_ channel. Calibration samples that do not complete the
// programmed count, and correction samples before the first calibration,
// are answered straight from the idle state. A corrected sample's eight
// products go through one shared 27x27 multiplier. The sample completing
// a calibration run uses three bit-serial square roots (26 steps each) and,
// unless the norm is zero, four bit-serial divisions (16 steps each). A new
// request is taken once the block is idle and the result register is free or
// being emptied. Write calib_samples only while the block is idle.
module accel_tilt_calibrate_correct (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [atc_pkg::CNT_W-1:0]          cfg_data,   // calib_samples
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [atc_pkg::IN_DATA_W-1:0]      s_tdata,    // accel_x, accel_y, accel_z
    input  logic                               s_tuser,    // func
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [atc_pkg::OUT_DATA_W-1:0]     m_tdata,    // corr_x, corr_y, corr_z, pad
    output logic [1:0]                         m_tuser     // is_calibrated, calib_done
);
    atc_pkg::cmd_t    cmd;
    atc_pkg::status_t status;

    atc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    atc_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );
endmodule
